[rtl/urem_pkg.sv]
// Package with the shared types, codes and constants of the uniform-run edge marker.
package urem_pkg;

  localparam int DEFAULT_RUN_LENGTH = 10;
  localparam int DEFAULT_MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT         = 1024;

  localparam int PIXEL_W  = 8;
  localparam int LABEL_W  = 8;
  localparam int REG_W    = 11;
  localparam int ROW_W    = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [REG_W-1:0] FRAME_WIDTH_RESET  = 11'd320;
  localparam logic [REG_W-1:0] FRAME_HEIGHT_RESET = 11'd240;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [PIXEL_W-1:0] PIXEL_BRIGHT = 8'd254;
  localparam logic [PIXEL_W-1:0] PIXEL_DARK   = 8'd0;

  localparam logic [LABEL_W-1:0] LABEL_BRIGHT = 8'd254;
  localparam logic [LABEL_W-1:0] LABEL_DARK   = 8'd0;
  localparam logic [LABEL_W-1:0] LABEL_NONE   = 8'd127;

  typedef enum logic [1:0] {
    CLS_NONE   = 2'd0,
    CLS_BRIGHT = 2'd1,
    CLS_DARK   = 2'd2
  } cls_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               frame_start;
  } in_word_t;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic               row_end;
    logic               frame_end;
  } out_word_t;

  function automatic cls_t classify(input logic [PIXEL_W-1:0] pix);
    cls_t c;
    if (pix == PIXEL_BRIGHT) begin
      c = CLS_BRIGHT;
    end else if (pix == PIXEL_DARK) begin
      c = CLS_DARK;
    end else begin
      c = CLS_NONE;
    end
    return c;
  endfunction

  function automatic logic [LABEL_W-1:0] class_label(input cls_t c);
    logic [LABEL_W-1:0] l;
    case (c)
      CLS_BRIGHT: l = LABEL_BRIGHT;
      CLS_DARK:   l = LABEL_DARK;
      default:    l = LABEL_NONE;
    endcase
    return l;
  endfunction

endpackage

[rtl/urem_cfg.sv]
// Frame size registers and their clamped effective values.
module urem_cfg #(
  parameter int MAX_WIDTH = urem_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [urem_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [urem_pkg::REG_W-1:0]          cfg_data,
  output logic [$clog2(MAX_WIDTH+1)-1:0]      eff_w,
  output logic [urem_pkg::REG_W-1:0]          eff_h
);

  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [urem_pkg::REG_W-1:0] width_r;
  logic [urem_pkg::REG_W-1:0] height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= urem_pkg::FRAME_WIDTH_RESET;
      height_r <= urem_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == urem_pkg::REG_FRAME_WIDTH) begin
        width_r <= cfg_data;
      end
      if (cfg_index == urem_pkg::REG_FRAME_HEIGHT) begin
        height_r <= cfg_data;
      end
    end
  end

  always_comb begin
    if (width_r == '0) begin
      eff_w = WW'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_r);
    end
    if (height_r == '0) begin
      eff_h = urem_pkg::REG_W'(1);
    end else if (int'(height_r) > urem_pkg::MAX_HEIGHT) begin
      eff_h = urem_pkg::REG_W'(urem_pkg::MAX_HEIGHT);
    end else begin
      eff_h = height_r;
    end
  end

endmodule

[rtl/urem_pos.sv]
// Raster position tracker giving column, row and delay slot of each accepted word.
module urem_pos #(
  parameter int RUN_LENGTH = urem_pkg::DEFAULT_RUN_LENGTH,
  parameter int MAX_WIDTH  = urem_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  logic                              frame_start,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    eff_w,
  input  logic [urem_pkg::REG_W-1:0]        eff_h,
  output logic [$clog2(MAX_WIDTH)-1:0]      col,
  output logic [urem_pkg::ROW_W-1:0]        row,
  output logic [$clog2(RUN_LENGTH)-1:0]     slot
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int SW = $clog2(RUN_LENGTH);
  localparam int HW = urem_pkg::REG_W;

  logic [CW-1:0] col_r, col_nxt;
  logic [urem_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [SW-1:0] slot_r, slot_nxt;

  logic [CW-1:0] c0;
  logic [urem_pkg::ROW_W-1:0] r0;
  logic [SW-1:0] s0, s1;
  logic [HW-1:0] r1, rn;
  logic [WW-1:0] cn;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    logic [SW-1:0] n;
    if (s == SW'(RUN_LENGTH - 1)) begin
      n = '0;
    end else begin
      n = s + SW'(1);
    end
    return n;
  endfunction

  always_comb begin
    c0 = frame_start ? '0 : col_r;
    r0 = frame_start ? '0 : row_r;
    s0 = frame_start ? '0 : slot_r;
    if (WW'(c0) >= eff_w) begin
      col = '0;
      r1  = HW'(r0) + HW'(1);
      s1  = slot_inc(s0);
    end else begin
      col = c0;
      r1  = HW'(r0);
      s1  = s0;
    end
    if (r1 >= eff_h) begin
      row  = '0;
      slot = '0;
    end else begin
      row  = r1[urem_pkg::ROW_W-1:0];
      slot = s1;
    end

    cn = WW'(col) + WW'(1);
    rn = HW'(row) + HW'(1);
    if (cn >= eff_w) begin
      col_nxt = '0;
      if (rn >= eff_h) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end else begin
        row_nxt  = rn[urem_pkg::ROW_W-1:0];
        slot_nxt = slot_inc(slot);
      end
    end else begin
      col_nxt  = cn[CW-1:0];
      row_nxt  = row;
      slot_nxt = slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else if (step) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
    end
  end

endmodule

[rtl/urem_ram.sv]
// Simple dual-port memory with one write port and one registered read port.
module urem_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/uniform_run_edge_marker.sv]
// Top level of the uniform-run edge marker: run decisions, delay memories and output register.
//
// The input channel takes one pixel word per clock while in_stall is low, in raster
// order; frame_start on a word makes it position (0, 0). Each accepted word in row
// RUN_LENGTH or below gives one result word, the label of the position RUN_LENGTH rows
// above, with row_end on the last column and frame_end on the last column of the last
// row. Words of the first RUN_LENGTH rows give no result; the bottom RUN_LENGTH rows are
// not sent. The frame size registers are written on the cfg port (index 0 width, 1 height)
// and are always ready.
// An accepted word is held in the second-stage registers and then its result in the
// output register. Throughput is one word per clock while nothing stalls, set by the
// single read and write port of the vertical run memory and of the flag memory.
// After reset the vertical run memory is cleared, one column per cycle, over all
// MAX_WIDTH columns, during which in_stall stays high.
// When out_stall holds a waiting result, the whole pipeline holds and in_stall
// rises in the same cycle; a free output register never stops the input.
module uniform_run_edge_marker #(
  parameter int RUN_LENGTH = urem_pkg::DEFAULT_RUN_LENGTH,
  parameter int MAX_WIDTH  = urem_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  urem_pkg::in_word_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output urem_pkg::out_word_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [urem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [urem_pkg::REG_W-1:0]     cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int SW  = $clog2(RUN_LENGTH);
  localparam int NW  = $clog2(RUN_LENGTH + 1);
  localparam int VW  = 2 + NW;
  localparam int FD  = RUN_LENGTH * MAX_WIDTH;
  localparam int FAW = $clog2(FD);
  localparam int KW  = WW + 1;
  localparam int HW  = urem_pkg::REG_W;

  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [CW-1:0] col_a;
  logic [urem_pkg::ROW_W-1:0] row_a;
  logic [SW-1:0] slot_a;

  logic en, accept;
  logic clr_busy_r;
  logic [CW-1:0] clr_addr_r;

  urem_pkg::cls_t cls_a;
  logic [FAW-1:0] fbase_a, fraddr_a, fwaddr_a;

  logic b_v_r, b_col0_r, b_row0_r, b_emit_r, b_col_ok_r;
  logic b_last_col_r, b_last_row_r, b_hwrite_r;
  logic [CW-1:0] b_col_r;
  urem_pkg::cls_t b_cls_r;
  logic [FAW-1:0] b_fwaddr_r;
  logic vbyp_r, fbyp_r;
  logic [VW-1:0] vbyp_d_r;
  logic [1:0] fbyp_d_r;

  urem_pkg::cls_t h_cls_r;
  logic [NW-1:0] h_cnt_r;

  logic [VW-1:0] vram_rd, vr, vram_wdata;
  logic [CW-1:0] vram_waddr;
  logic vram_we;
  logic [1:0] fram_rd, fr;
  logic fram_we;

  urem_pkg::cls_t vcls_old, hflag, flag_w;
  logic [NW-1:0] vcnt_old, hc, vc;
  logic [VW-1:0] vwdata;
  logic [urem_pkg::LABEL_W-1:0] label;

  logic out_valid_r;
  urem_pkg::out_word_t out_data_r;

  function automatic logic [NW-1:0] next_count(
    input logic           restart,
    input urem_pkg::cls_t cls,
    input urem_pkg::cls_t old_cls,
    input logic [NW-1:0]  old_cnt
  );
    logic [NW-1:0] n;
    if (cls == urem_pkg::CLS_NONE) begin
      n = '0;
    end else if (restart || cls != old_cls) begin
      n = NW'(1);
    end else if (old_cnt >= NW'(RUN_LENGTH)) begin
      n = NW'(RUN_LENGTH);
    end else begin
      n = old_cnt + NW'(1);
    end
    return n;
  endfunction

  urem_cfg #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .eff_w    (eff_w),
    .eff_h    (eff_h)
  );

  urem_pos #(
    .RUN_LENGTH(RUN_LENGTH),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pos (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (accept),
    .frame_start(in_data.frame_start),
    .eff_w      (eff_w),
    .eff_h      (eff_h),
    .col        (col_a),
    .row        (row_a),
    .slot       (slot_a)
  );

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en || clr_busy_r;
  assign accept   = in_valid && !in_stall;

  // Decode of the incoming word and the memory addresses it touches.
  assign cls_a    = urem_pkg::classify(in_data.pixel);
  assign fbase_a  = FAW'(slot_a) * FAW'(MAX_WIDTH);
  assign fraddr_a = fbase_a + FAW'(col_a);
  assign fwaddr_a = fbase_a + FAW'(col_a - CW'(RUN_LENGTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + CW'(1);
      if (clr_addr_r == CW'(MAX_WIDTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_col_r      <= col_a;
      b_cls_r      <= cls_a;
      b_col0_r     <= (col_a == '0);
      b_row0_r     <= (row_a == '0);
      b_emit_r     <= (row_a >= urem_pkg::ROW_W'(RUN_LENGTH));
      b_col_ok_r   <= ((KW'(col_a) + KW'(RUN_LENGTH)) < KW'(eff_w));
      b_last_col_r <= (WW'(col_a) == eff_w - WW'(1));
      b_last_row_r <= (HW'(row_a) == eff_h - HW'(1));
      b_hwrite_r   <= (col_a >= CW'(RUN_LENGTH - 1));
      b_fwaddr_r   <= fwaddr_a;
      // The word in the second stage writes at this same edge; forward its data.
      vbyp_r       <= b_v_r && (b_col_r == col_a);
      vbyp_d_r     <= vwdata;
      fbyp_r       <= b_v_r && b_hwrite_r && (b_fwaddr_r == fraddr_a);
      fbyp_d_r     <= flag_w;
    end
  end

  assign vr       = vbyp_r ? vbyp_d_r : vram_rd;
  assign fr       = fbyp_r ? fbyp_d_r : fram_rd;
  assign vcls_old = urem_pkg::cls_t'(vr[VW-1 -: 2]);
  assign vcnt_old = vr[NW-1:0];
  assign hflag    = urem_pkg::cls_t'(fr);

  always_comb begin
    hc     = next_count(b_col0_r, b_cls_r, h_cls_r, h_cnt_r);
    flag_w = (hc >= NW'(RUN_LENGTH)) ? b_cls_r : urem_pkg::CLS_NONE;
    vc     = next_count(b_row0_r, b_cls_r, vcls_old, vcnt_old);
    vwdata = {b_cls_r, vc};
    label  = urem_pkg::LABEL_NONE;
    if (b_col_ok_r) begin
      if (hflag == urem_pkg::CLS_BRIGHT || hflag == urem_pkg::CLS_DARK) begin
        label = urem_pkg::class_label(hflag);
      end else if (vcnt_old >= NW'(RUN_LENGTH) &&
                   (vcls_old == urem_pkg::CLS_BRIGHT || vcls_old == urem_pkg::CLS_DARK)) begin
        label = urem_pkg::class_label(vcls_old);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_cls_r <= urem_pkg::CLS_NONE;
      h_cnt_r <= '0;
    end else if (en && b_v_r) begin
      h_cls_r <= b_cls_r;
      h_cnt_r <= hc;
    end
  end

  assign vram_we    = clr_busy_r || (en && b_v_r);
  assign vram_waddr = clr_busy_r ? clr_addr_r : b_col_r;
  assign vram_wdata = clr_busy_r ? '0 : vwdata;
  assign fram_we    = en && b_v_r && b_hwrite_r;

  urem_ram #(
    .DEPTH(MAX_WIDTH),
    .WIDTH(VW)
  ) u_vram (
    .clk  (clk),
    .we   (vram_we),
    .waddr(vram_waddr),
    .wdata(vram_wdata),
    .re   (accept),
    .raddr(col_a),
    .rdata(vram_rd)
  );

  urem_ram #(
    .DEPTH(FD),
    .WIDTH(2)
  ) u_fram (
    .clk  (clk),
    .we   (fram_we),
    .waddr(b_fwaddr_r),
    .wdata(flag_w),
    .re   (accept),
    .raddr(fraddr_a),
    .rdata(fram_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= b_v_r && b_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.label     <= label;
      out_data_r.row_end   <= b_last_col_r;
      out_data_r.frame_end <= b_last_col_r && b_last_row_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_hcnt_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    h_cnt_r <= NW'(RUN_LENGTH))
    else $error("Horizontal run count is above the run length.");

  a_no_word_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !b_v_r && !out_valid_r)
    else $error("A word is in flight during the clearing pass.");

  a_emit_not_first_row: assert property (@(posedge clk) disable iff (!rst_n)
    (b_v_r && b_emit_r) |-> !b_row0_r)
    else $error("A result is due for a word of the first row.");

  a_result_follows_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (en && !(b_v_r && b_emit_r)) |=> !out_valid_r)
    else $error("A result appeared without an emitting word in the second stage.");

endmodule
